>>> rtl/tmsu_pkg.sv
package tmsu_pkg;

  // default sizes of the banks
  localparam int NUM_MUTEXES_DEF    = 8;
  localparam int NUM_SEMAPHORES_DEF = 8;
  localparam int COUNT_BITS_DEF     = 4;

  // operation codes
  localparam logic [2:0] KIND_ACQUIRE = 3'd0;
  localparam logic [2:0] KIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_INIT    = 3'd2;
  localparam logic [2:0] KIND_POST    = 3'd3;
  localparam logic [2:0] KIND_GET     = 3'd4;
  localparam logic [2:0] KIND_STATUS  = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] thread_num;
    logic [2:0] mtx_idx;
    logic [7:0] sem_select;
    logic [3:0] limit_value;
    logic [3:0] start_value;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic       mutex_free_for_thread;
    logic [3:0] sem_value;
    logic       sem_is_zero;
    logic       sem_is_max;
    logic       select_error;
  } rsp_t;

  // mutex bank answer
  typedef struct packed {
    logic granted;
    logic mutex_free_for_thread;
  } mtx_rsp_t;

  // semaphore bank answer
  typedef struct packed {
    logic [3:0] sem_value;
    logic       sem_is_zero;
    logic       sem_is_max;
    logic       select_error;
  } sem_rsp_t;

endpackage

>>> rtl/thread_mutex_semaphore_unit_top.sv
// a request taken at a clock edge sits in the input register, its result is loaded into
// the result register at the next edge and marked by done for one cycle
// throughput: one request per cycle; busy is only high during reset
// the result is shown for a single cycle and the receiver cannot stall it
// reset (synchronous, active high) frees all mutexes, zeroes owners, counts and maxima
module thread_mutex_semaphore_unit_top
  import tmsu_pkg::*;
#(
  parameter int NUM_MUTEXES    = NUM_MUTEXES_DEF,
  parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
  parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t result
);

  // captured request
  req_t     req_q;
  logic     req_vld;
  // answers from the two banks
  mtx_rsp_t mtx_rsp;
  sem_rsp_t sem_rsp;

  // nothing blocks a request except reset
  assign busy = rst;

  // input register: the request waits here while the banks work on it
  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else begin
      req_vld <= start;
    end
    req_q <= req;
  end

  // mutex bank: owner check, take and release
  tmsu_mutex_bank #(
    .NUM_MUTEXES (NUM_MUTEXES)
  ) u_mutex_bank (
    .clk        (clk),
    .rst        (rst),
    .en         (req_vld),
    .kind       (req_q.kind),
    .thread_num (req_q.thread_num),
    .mtx_idx    (req_q.mtx_idx),
    .rsp        (mtx_rsp)
  );

  // semaphore bank: one-hot select check, init, saturating post and get
  tmsu_sem_bank #(
    .NUM_SEMAPHORES (NUM_SEMAPHORES),
    .COUNT_BITS     (COUNT_BITS)
  ) u_sem_bank (
    .clk         (clk),
    .rst         (rst),
    .en          (req_vld),
    .kind        (req_q.kind),
    .sem_select  (req_q.sem_select),
    .limit_value (req_q.limit_value),
    .start_value (req_q.start_value),
    .rsp         (sem_rsp)
  );

  // result register: loads at the same edge at which the bank state updates,
  // so the next request already sees the new state
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_vld;
    end
    result.granted               <= mtx_rsp.granted;
    result.mutex_free_for_thread <= mtx_rsp.mutex_free_for_thread;
    result.sem_value             <= sem_rsp.sem_value;
    result.sem_is_zero           <= sem_rsp.sem_is_zero;
    result.sem_is_max            <= sem_rsp.sem_is_max;
    result.select_error          <= sem_rsp.select_error;
  end

endmodule

>>> rtl/tmsu_mutex_bank.sv
module tmsu_mutex_bank
  import tmsu_pkg::*;
#(
  parameter int NUM_MUTEXES = NUM_MUTEXES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [2:0] kind,
  input  logic [1:0] thread_num,
  input  logic [2:0] mtx_idx,
  output mtx_rsp_t   rsp
);

  logic       held       [NUM_MUTEXES];
  logic [1:0] owner      [NUM_MUTEXES];
  logic       held_next  [NUM_MUTEXES];
  logic [1:0] owner_next [NUM_MUTEXES];
  logic       hit        [NUM_MUTEXES];

  always_comb begin
    rsp = '0;
    for (int i = 0; i < NUM_MUTEXES; i++) begin
      hit[i]        = (32'(mtx_idx) == i);
      held_next[i]  = held[i];
      owner_next[i] = owner[i];
      if (en && hit[i]) begin
        if (kind == KIND_ACQUIRE) begin
          if (!held[i] || owner[i] == thread_num) begin
            held_next[i]  = 1'b1;
            owner_next[i] = thread_num;
            rsp.granted   = 1'b1;
          end
        end else if (kind == KIND_RELEASE) begin
          if (held[i] && owner[i] == thread_num) begin
            held_next[i] = 1'b0;
          end
        end
      end
      // state after the operation, reported for every defined kind
      if (hit[i] && kind <= KIND_STATUS) begin
        rsp.mutex_free_for_thread = !held_next[i] || owner_next[i] == thread_num;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_MUTEXES; i++) begin
      if (rst) begin
        held[i]  <= 1'b0;
        owner[i] <= '0;
      end else begin
        held[i]  <= held_next[i];
        owner[i] <= owner_next[i];
      end
    end
  end

endmodule

>>> rtl/tmsu_sem_bank.sv
module tmsu_sem_bank
  import tmsu_pkg::*;
#(
  parameter int NUM_SEMAPHORES = NUM_SEMAPHORES_DEF,
  parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [2:0] kind,
  input  logic [7:0] sem_select,
  input  logic [3:0] limit_value,
  input  logic [3:0] start_value,
  output sem_rsp_t   rsp
);

  logic [COUNT_BITS-1:0] count      [NUM_SEMAPHORES];
  logic [COUNT_BITS-1:0] limit      [NUM_SEMAPHORES];
  logic [COUNT_BITS-1:0] count_next [NUM_SEMAPHORES];
  logic [COUNT_BITS-1:0] limit_next [NUM_SEMAPHORES];
  logic [COUNT_BITS-1:0] sel_count;
  logic [COUNT_BITS-1:0] sel_limit;
  logic                  sem_op;
  logic                  sel_ok;

  always_comb begin
    sem_op    = (kind >= KIND_INIT) && (kind <= KIND_STATUS);
    // exactly one bit, and that bit inside the bank
    sel_ok    = $onehot(sem_select) && ((16'(sem_select) >> NUM_SEMAPHORES) == '0);
    sel_count = '0;
    sel_limit = '0;
    for (int i = 0; i < NUM_SEMAPHORES; i++) begin
      count_next[i] = count[i];
      limit_next[i] = limit[i];
      if (en && sem_op && sel_ok && sem_select[i]) begin
        case (kind)
          KIND_INIT: begin
            count_next[i] = COUNT_BITS'(start_value);
            limit_next[i] = COUNT_BITS'(limit_value);
          end
          KIND_POST: begin
            if (count[i] < limit[i]) begin
              count_next[i] = count[i] + 1'b1;
            end
          end
          KIND_GET: begin
            if (count[i] != '0) begin
              count_next[i] = count[i] - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (sem_select[i]) begin
        sel_count = sel_count | count_next[i];
        sel_limit = sel_limit | limit_next[i];
      end
    end

    rsp = '0;
    if (sem_op) begin
      if (!sel_ok) begin
        rsp.select_error = 1'b1;
      end else begin
        rsp.sem_value   = 4'(sel_count);
        rsp.sem_is_zero = (sel_count == '0);
        rsp.sem_is_max  = (sel_count == sel_limit);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SEMAPHORES; i++) begin
      if (rst) begin
        count[i] <= '0;
        limit[i] <= '0;
      end else begin
        count[i] <= count_next[i];
        limit[i] <= limit_next[i];
      end
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
  import tmsu_pkg::*;

  // kinds the unit decodes as no-ops
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  localparam int RANDOM_OPS   = 1325;
  localparam int TAIL_CYCLES  = 6;    // pipeline holds an input and a result register
  localparam int STALL_LIMIT  = 500;
  localparam int REPORT_LIMIT = 10;
  localparam int CALM_TAIL    = 150;  // no idling for the last requests

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t req = '0;
  rsp_t result;

  thread_mutex_semaphore_unit_top uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // shadow copy of the lock and semaphore banks, reset state is all zero
  logic       lock_taken [NUM_MUTEXES_DEF] = '{default: 1'b0};
  logic [1:0] lock_holder[NUM_MUTEXES_DEF] = '{default: 2'd0};
  logic [3:0] sem_level  [NUM_SEMAPHORES_DEF] = '{default: 4'd0};
  logic [3:0] sem_ceiling[NUM_SEMAPHORES_DEF] = '{default: 4'd0};

  req_t ops_to_issue[$];   // requests not yet handed to the unit
  rsp_t outcomes_due[$];   // predicted answers, oldest first
  int   ops_total;
  int   ops_taken  = 0;
  int   faults     = 0;
  int   gap_left   = 0;
  int   stall_count = 0;

  // applies one request to the shadow banks and returns the answer it should give
  function automatic rsp_t sync_op_outcome(req_t r);
    rsp_t       o;
    int         s;
    logic       hit;
    logic [2:0] m;
    o   = '0;
    s   = 0;
    hit = 1'b0;
    m   = r.mtx_idx;
    if (r.kind > KIND_STATUS) return o;  // spare kinds answer all zero

    // mutex side
    if (r.kind == KIND_ACQUIRE) begin
      if (!lock_taken[m] || lock_holder[m] == r.thread_num) begin
        lock_taken[m]  = 1'b1;
        lock_holder[m] = r.thread_num;
        o.granted      = 1'b1;
      end
    end else if (r.kind == KIND_RELEASE) begin
      // only the owner may free it
      if (lock_taken[m] && lock_holder[m] == r.thread_num) lock_taken[m] = 1'b0;
    end
    o.mutex_free_for_thread = !lock_taken[m] || lock_holder[m] == r.thread_num;

    // semaphore side, skipped by mutex operations
    if (r.kind >= KIND_INIT) begin
      for (int i = 0; i < NUM_SEMAPHORES_DEF; i++) begin
        if (r.sem_select == 8'(1 << i)) begin
          hit = 1'b1;
          s   = i;
        end
      end
      if (!hit) begin
        o.select_error = 1'b1;
      end else begin
        case (r.kind)
          KIND_INIT: begin
            sem_level[s]   = r.start_value;
            sem_ceiling[s] = r.limit_value;
          end
          KIND_POST: begin
            if (sem_level[s] < sem_ceiling[s]) sem_level[s] = sem_level[s] + 4'd1;
          end
          KIND_GET: begin
            if (sem_level[s] != 4'd0) sem_level[s] = sem_level[s] - 4'd1;
          end
          default: begin
          end
        endcase
        o.sem_value   = sem_level[s];
        o.sem_is_zero = sem_level[s] == 4'd0;
        o.sem_is_max  = sem_level[s] == sem_ceiling[s];
      end
    end
    return o;
  endfunction

  function automatic req_t op(logic [2:0] kind, logic [1:0] tid, logic [2:0] midx,
                              logic [7:0] sel, logic [3:0] lim, logic [3:0] cnt);
    req_t r;
    r.kind        = kind;
    r.thread_num  = tid;
    r.mtx_idx     = midx;
    r.sem_select  = sel;
    r.limit_value = lim;
    r.start_value = cnt;
    return r;
  endfunction

  // mostly well-formed traffic with heavy lock contention among four threads
  function automatic req_t random_op();
    req_t r;
    int   pick;
    pick          = $urandom_range(0, 99);
    r.thread_num  = 2'($urandom_range(0, 3));
    r.mtx_idx     = 3'($urandom_range(0, 7));
    r.limit_value = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) < 7) r.start_value = 4'($urandom_range(0, r.limit_value));
    else r.start_value = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 88) r.sem_select = 8'(1 << $urandom_range(0, 7));
    else r.sem_select = 8'($urandom_range(0, 255));
    if (pick < 22)      r.kind = KIND_ACQUIRE;
    else if (pick < 40) r.kind = KIND_RELEASE;
    else if (pick < 52) r.kind = KIND_INIT;
    else if (pick < 70) r.kind = KIND_POST;
    else if (pick < 88) r.kind = KIND_GET;
    else if (pick < 98) r.kind = KIND_STATUS;
    else if (pick < 99) r.kind = KIND_SPARE_A;
    else                r.kind = KIND_SPARE_B;
    return r;
  endfunction

  function automatic string show(rsp_t r);
    return $sformatf("granted=%0d free=%0d value=%0d zero=%0d max=%0d sel_err=%0d",
                     r.granted, r.mutex_free_for_thread, r.sem_value,
                     r.sem_is_zero, r.sem_is_max, r.select_error);
  endfunction

  // driver: one request per accepted handshake, random idle bursts in between
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        outcomes_due.push_back(sync_op_outcome(req));
        ops_taken++;
      end
      // a request that is not yet taken stays on the bus unchanged
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (ops_to_issue.size() > 0) begin
          // idling is off for one hundred requests in every four hundred and for the tail
          if (ops_to_issue.size() > CALM_TAIL && (ops_to_issue.size() / 100) % 4 != 0 &&
              $urandom_range(0, 5) == 0) begin
            start    <= 1'b0;
            gap_left = $urandom_range(0, 14);
          end else begin
            req   <= ops_to_issue.pop_front();
            start <= 1'b1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed answer must match the oldest prediction
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (outcomes_due.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT) $display("unexpected answer: %s", show(result));
      end else begin
        want = outcomes_due.pop_front();
        if (result.granted !== want.granted ||
            result.mutex_free_for_thread !== want.mutex_free_for_thread ||
            result.sem_value !== want.sem_value ||
            result.sem_is_zero !== want.sem_is_zero ||
            result.sem_is_max !== want.sem_is_max ||
            result.select_error !== want.select_error) begin
          faults++;
          if (faults <= REPORT_LIMIT) begin
            $display("mismatch at %0t: expected %s", $realtime, show(want));
            $display("                 actual   %s", show(result));
          end
        end
      end
    end
  end

  // watchdog on cycles where neither side moves anything
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    // fresh unit: semaphore 0 reads zero count at a zero maximum
    ops_to_issue.push_back(op(KIND_STATUS,  2'd0, 3'd0, 8'h01, 4'd0,  4'd0));
    // contention on one mutex: take, refuse, re-enter, foreign release
    ops_to_issue.push_back(op(KIND_ACQUIRE, 2'd1, 3'd0, 8'hFF, 4'd15, 4'd15));
    ops_to_issue.push_back(op(KIND_ACQUIRE, 2'd2, 3'd0, 8'h00, 4'd0,  4'd0));
    ops_to_issue.push_back(op(KIND_ACQUIRE, 2'd1, 3'd0, 8'h01, 4'd7,  4'd3));
    ops_to_issue.push_back(op(KIND_RELEASE, 2'd2, 3'd0, 8'h02, 4'd1,  4'd9));
    ops_to_issue.push_back(op(KIND_STATUS,  2'd2, 3'd0, 8'h02, 4'd0,  4'd0));
    ops_to_issue.push_back(op(KIND_RELEASE, 2'd1, 3'd0, 8'h04, 4'd0,  4'd0));
    ops_to_issue.push_back(op(KIND_STATUS,  2'd2, 3'd0, 8'h08, 4'd0,  4'd0));
    // highest mutex and thread
    ops_to_issue.push_back(op(KIND_ACQUIRE, 2'd3, 3'd7, 8'h80, 4'd15, 4'd15));
    ops_to_issue.push_back(op(KIND_STATUS,  2'd0, 3'd7, 8'h80, 4'd0,  4'd0));
    ops_to_issue.push_back(op(KIND_RELEASE, 2'd3, 3'd7, 8'h40, 4'd0,  4'd0));
    // full-range semaphore saturating at its maximum
    ops_to_issue.push_back(op(KIND_INIT,    2'd0, 3'd1, 8'h80, 4'd15, 4'd15));
    ops_to_issue.push_back(op(KIND_POST,    2'd0, 3'd1, 8'h80, 4'd0,  4'd0));
    ops_to_issue.push_back(op(KIND_GET,     2'd0, 3'd1, 8'h80, 4'd0,  4'd0));
    // empty semaphore with zero maximum: get and post both stick
    ops_to_issue.push_back(op(KIND_INIT,    2'd1, 3'd2, 8'h01, 4'd0,  4'd0));
    ops_to_issue.push_back(op(KIND_GET,     2'd1, 3'd2, 8'h01, 4'd15, 4'd15));
    ops_to_issue.push_back(op(KIND_POST,    2'd1, 3'd2, 8'h01, 4'd15, 4'd15));
    // count loaded above the maximum: post holds, get still counts down
    ops_to_issue.push_back(op(KIND_INIT,    2'd2, 3'd3, 8'h02, 4'd3,  4'd9));
    ops_to_issue.push_back(op(KIND_POST,    2'd2, 3'd3, 8'h02, 4'd0,  4'd0));
    ops_to_issue.push_back(op(KIND_GET,     2'd2, 3'd3, 8'h02, 4'd0,  4'd0));
    // selects that are not one-hot
    ops_to_issue.push_back(op(KIND_INIT,    2'd3, 3'd4, 8'h00, 4'd5,  4'd5));
    ops_to_issue.push_back(op(KIND_POST,    2'd3, 3'd4, 8'h03, 4'd5,  4'd5));
    ops_to_issue.push_back(op(KIND_GET,     2'd3, 3'd4, 8'hFF, 4'd5,  4'd5));
    ops_to_issue.push_back(op(KIND_STATUS,  2'd0, 3'd5, 8'h81, 4'd0,  4'd0));
    // post up to the maximum, then the spare kinds with busy fields
    ops_to_issue.push_back(op(KIND_INIT,    2'd0, 3'd6, 8'h10, 4'd5,  4'd4));
    ops_to_issue.push_back(op(KIND_POST,    2'd0, 3'd6, 8'h10, 4'd0,  4'd0));
    ops_to_issue.push_back(op(KIND_SPARE_A, 2'd3, 3'd7, 8'h20, 4'd15, 4'd15));
    ops_to_issue.push_back(op(KIND_SPARE_B, 2'd3, 3'd7, 8'h10, 4'd15, 4'd15));
    for (int i = 0; i < RANDOM_OPS; i++) ops_to_issue.push_back(random_op());
    ops_total = ops_to_issue.size();

    while (ops_taken < ops_total || outcomes_due.size() != 0) @(posedge clk);
    // let any stray answer show up before judging
    repeat (TAIL_CYCLES) @(posedge clk);
    if (faults == 0 && outcomes_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tmsu_pkg.sv
rtl/tmsu_mutex_bank.sv
rtl/tmsu_sem_bank.sv
rtl/thread_mutex_semaphore_unit_top.sv
test/tb.sv
